### design/mked_pkg.sv
`timescale 1ns / 1ps

package mked_pkg;

    // key count and derived widths
    localparam int NUM_KEYS  = 4;
    localparam int KEY_W     = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int LEVEL_W   = 4;
    localparam int INDEX_W   = 2;
    localparam int FLAG_W    = 7;
    localparam int TIMER_W   = 16;
    localparam int SCAN_W    = 8;

    // apb register map
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // register indexes
    localparam logic [1:0] REG_SCAN_DIVIDER = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS   = 2'd1;
    localparam logic [1:0] REG_DOUBLE_GAP   = 2'd2;
    localparam logic [1:0] REG_REPEAT       = 2'd3;

    // register reset values
    localparam logic [SCAN_W-1:0]  SCAN_DIVIDER_RST = 8'd20;
    localparam logic [TIMER_W-1:0] LONG_PRESS_RST   = 16'd2000;
    localparam logic [TIMER_W-1:0] DOUBLE_GAP_RST   = 16'd200;
    localparam logic [TIMER_W-1:0] REPEAT_RST       = 16'd100;

    // event flag bits
    localparam logic [FLAG_W-1:0] FLAG_HELD   = 7'h01;
    localparam logic [FLAG_W-1:0] FLAG_DOWN   = 7'h02;
    localparam logic [FLAG_W-1:0] FLAG_UP     = 7'h04;
    localparam logic [FLAG_W-1:0] FLAG_DOUBLE = 7'h08;
    localparam logic [FLAG_W-1:0] FLAG_SINGLE = 7'h10;
    localparam logic [FLAG_W-1:0] FLAG_LONG   = 7'h20;
    localparam logic [FLAG_W-1:0] FLAG_REPEAT = 7'h40;

    // command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    // per-key gesture phase
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HELD   = 3'd1,
        PH_GAP    = 3'd2,
        PH_SECOND = 3'd3,
        PH_REPEAT = 3'd4
    } t_phase;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_CHECK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [SCAN_W-1:0]  scan_divider;
        logic [TIMER_W-1:0] long_press_ticks;
        logic [TIMER_W-1:0] double_gap_ticks;
        logic [TIMER_W-1:0] repeat_ticks;
    } t_cfg;

    typedef struct packed {
        logic load_in;
        logic step_key;
        logic do_check;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic last_key;
        logic slot_free;
    } t_status;

endpackage

### design/mked_ctrl.sv
`timescale 1ns / 1ps

module mked_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_cmd,
    input  mked_pkg::t_status i_status,
    output logic              o_in_ready,
    output mked_pkg::t_cmd    o_cmd
);

    mked_pkg::t_state r_state;
    mked_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mked_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            mked_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = (i_cmd == mked_pkg::CMD_CHECK) ? mked_pkg::ST_CHECK
                                                             : mked_pkg::ST_WALK;
                end
            end
            mked_pkg::ST_WALK: begin
                o_cmd.step_key = 1'b1;
                if (i_status.last_key) begin
                    n_state = mked_pkg::ST_DONE;
                end
            end
            mked_pkg::ST_CHECK: begin
                o_cmd.do_check = 1'b1;
                n_state = mked_pkg::ST_DONE;
            end
            mked_pkg::ST_DONE: begin
                if (i_status.slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = mked_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mked_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### design/mked_dp.sv
`timescale 1ns / 1ps

module mked_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mked_pkg::t_cfg                  i_cfg,
    input  mked_pkg::t_cmd                  i_ctl,
    output mked_pkg::t_status               o_status,
    input  logic                            i_cmd,
    input  logic [mked_pkg::LEVEL_W-1:0]    i_key_levels,
    input  logic [mked_pkg::INDEX_W-1:0]    i_key_index,
    input  logic [mked_pkg::FLAG_W-1:0]     i_flag_mask,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_hit
);

    localparam int KC = mked_pkg::NUM_KEYS;
    localparam int KW = mked_pkg::KEY_W;
    localparam int FW = mked_pkg::FLAG_W;
    localparam int TW = mked_pkg::TIMER_W;
    localparam int SW = mked_pkg::SCAN_W;

    // latched word
    logic [mked_pkg::LEVEL_W-1:0] r_levels;
    logic [FW-1:0]                r_mask;
    logic                         r_sample;
    logic                         r_idx_ok;
    logic [KW-1:0]                r_key;
    logic [SW-1:0]                r_scan_count;
    logic                         r_hit;
    logic                         r_out_valid;
    logic                         r_out_hit;

    // per-key state
    logic            r_level_now    [KC];
    logic            r_level_before [KC];
    mked_pkg::t_phase r_phase       [KC];
    logic [TW-1:0]   r_timer        [KC];
    logic [FW-1:0]   r_flags        [KC];

    // next values for the addressed key
    logic            n_level_now;
    logic            n_level_before;
    mked_pkg::t_phase n_phase;
    logic [TW-1:0]   n_timer;
    logic [FW-1:0]   n_flags;
    logic            n_hit;

    logic [SW-1:0]   scan_inc;
    logic            scan_hit;
    logic [mked_pkg::LEVEL_W-1:0] lvl_shift;
    logic            lvl;
    logic [TW-1:0]   t_dec;
    logic [FW-1:0]   masked;

    // scan divider compare at acceptance
    assign scan_inc = r_scan_count + SW'(1);
    assign scan_hit = (scan_inc >= i_cfg.scan_divider);

    // level of the addressed key, keys past the level field read unpressed
    assign lvl_shift = r_levels >> r_key;
    assign lvl       = lvl_shift[0];

    assign t_dec  = (r_timer[r_key] != '0) ? (r_timer[r_key] - TW'(1)) : '0;
    assign masked = r_flags[r_key] & r_mask;

    // per-key update: timer countdown, sampling and gesture phase
    always_comb begin
        n_level_now    = r_level_now[r_key];
        n_level_before = r_level_before[r_key];
        n_phase        = r_phase[r_key];
        n_timer        = t_dec;
        n_flags        = r_flags[r_key];
        n_hit          = 1'b0;
        if (i_ctl.do_check) begin
            n_timer = r_timer[r_key];
            n_hit   = r_idx_ok && (masked != '0);
            if (n_hit) begin
                n_flags = r_flags[r_key] & ~(r_mask & ~mked_pkg::FLAG_HELD);
            end
        end else if (r_sample) begin
            n_level_before = r_level_now[r_key];
            n_level_now    = lvl;
            if (lvl) begin
                n_flags = n_flags | mked_pkg::FLAG_HELD;
            end else begin
                n_flags = n_flags & ~mked_pkg::FLAG_HELD;
            end
            if (lvl && !r_level_now[r_key]) begin
                n_flags = n_flags | mked_pkg::FLAG_DOWN;
            end
            if (!lvl && r_level_now[r_key]) begin
                n_flags = n_flags | mked_pkg::FLAG_UP;
            end
            case (r_phase[r_key])
                mked_pkg::PH_IDLE: begin
                    if (lvl) begin
                        n_timer = i_cfg.long_press_ticks;
                        n_phase = mked_pkg::PH_HELD;
                    end
                end
                mked_pkg::PH_HELD: begin
                    if (!lvl) begin
                        n_timer = i_cfg.double_gap_ticks;
                        n_phase = mked_pkg::PH_GAP;
                    end else if (t_dec == '0) begin
                        n_timer = i_cfg.repeat_ticks;
                        n_flags = n_flags | mked_pkg::FLAG_LONG;
                        n_phase = mked_pkg::PH_REPEAT;
                    end
                end
                mked_pkg::PH_GAP: begin
                    if (lvl) begin
                        n_flags = n_flags | mked_pkg::FLAG_DOUBLE;
                        n_phase = mked_pkg::PH_SECOND;
                    end else if (t_dec == '0) begin
                        n_flags = n_flags | mked_pkg::FLAG_SINGLE;
                        n_phase = mked_pkg::PH_IDLE;
                    end
                end
                mked_pkg::PH_SECOND: begin
                    if (!lvl) begin
                        n_phase = mked_pkg::PH_IDLE;
                    end
                end
                mked_pkg::PH_REPEAT: begin
                    if (!lvl) begin
                        n_phase = mked_pkg::PH_IDLE;
                    end else if (t_dec == '0) begin
                        n_timer = i_cfg.repeat_ticks;
                        n_flags = n_flags | mked_pkg::FLAG_REPEAT;
                    end
                end
                default: begin
                    n_phase = mked_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // key state storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KC; k++) begin
                r_level_now[k]    <= 1'b0;
                r_level_before[k] <= 1'b0;
                r_phase[k]        <= mked_pkg::PH_IDLE;
                r_timer[k]        <= '0;
                r_flags[k]        <= '0;
            end
        end else if (i_ctl.step_key || i_ctl.do_check) begin
            r_level_now[r_key]    <= n_level_now;
            r_level_before[r_key] <= n_level_before;
            r_phase[r_key]        <= n_phase;
            r_timer[r_key]        <= n_timer;
            r_flags[r_key]        <= n_flags;
        end
    end

    // word latch, key walk and scan counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_count <= '0;
            r_key        <= '0;
            r_sample     <= 1'b0;
            r_idx_ok     <= 1'b0;
            r_hit        <= 1'b0;
        end else if (i_ctl.load_in) begin
            r_levels <= i_key_levels;
            r_mask   <= i_flag_mask;
            r_hit    <= 1'b0;
            if (i_cmd == mked_pkg::CMD_CHECK) begin
                r_key    <= KW'(i_key_index);
                r_idx_ok <= (32'(i_key_index) < KC);
                r_sample <= 1'b0;
            end else begin
                r_key        <= '0;
                r_idx_ok     <= 1'b0;
                r_sample     <= scan_hit;
                r_scan_count <= scan_hit ? '0 : scan_inc;
            end
        end else if (i_ctl.step_key) begin
            r_key <= o_status.last_key ? '0 : (r_key + KW'(1));
        end else if (i_ctl.do_check) begin
            r_hit <= n_hit;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_out_hit <= r_hit;
        end
    end

    assign o_status.last_key  = (32'(r_key) == KC - 1);
    assign o_status.slot_free = !r_out_valid || i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_hit              = r_out_hit;

endmodule

### design/multi_key_event_detector.sv
`timescale 1ns / 1ps

// Multi-key gesture detector. Each input word is either a tick (i_cmd = 0)
// carrying the pressed level of every key, or a check (i_cmd = 1) that
// tests the flags of key i_key_index against i_flag_mask and clears the
// tested event bits (the held bit is never cleared); every word yields one
// result word whose o_hit is 1 only for a check that found a masked flag.
// For a tick the key state is walked one key per clock through a single
// update path, then the result is loaded into the output register once
// that register is free. A check updates only the addressed key. A new word
// is accepted once the previous one has reached the output register, so
// a waiting result does not block the input. The timing registers sit on
// the APB port at 0x0 (scan divider), 0x4 (long press), 0x8 (double gap)
// and 0xC (repeat period); write them only while the block is idle.
module multi_key_event_detector (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // apb configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mked_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [mked_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [mked_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    // input words
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_cmd,
    input  logic [mked_pkg::LEVEL_W-1:0]         i_key_levels,
    input  logic [mked_pkg::INDEX_W-1:0]         i_key_index,
    input  logic [mked_pkg::FLAG_W-1:0]          i_flag_mask,
    // result words
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_hit
);

    mked_pkg::t_cfg    r_cfg;
    mked_pkg::t_cmd    ctl;
    mked_pkg::t_status status;
    logic              wr_en;
    logic [1:0]        reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scan_divider     <= mked_pkg::SCAN_DIVIDER_RST;
            r_cfg.long_press_ticks <= mked_pkg::LONG_PRESS_RST;
            r_cfg.double_gap_ticks <= mked_pkg::DOUBLE_GAP_RST;
            r_cfg.repeat_ticks     <= mked_pkg::REPEAT_RST;
        end else if (wr_en) begin
            case (reg_sel)
                mked_pkg::REG_SCAN_DIVIDER: r_cfg.scan_divider <= pwdata[7:0];
                mked_pkg::REG_LONG_PRESS:   r_cfg.long_press_ticks <= pwdata[15:0];
                mked_pkg::REG_DOUBLE_GAP:   r_cfg.double_gap_ticks <= pwdata[15:0];
                mked_pkg::REG_REPEAT:       r_cfg.repeat_ticks <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_sel)
            mked_pkg::REG_SCAN_DIVIDER: prdata = 32'(r_cfg.scan_divider);
            mked_pkg::REG_LONG_PRESS:   prdata = 32'(r_cfg.long_press_ticks);
            mked_pkg::REG_DOUBLE_GAP:   prdata = 32'(r_cfg.double_gap_ticks);
            mked_pkg::REG_REPEAT:       prdata = 32'(r_cfg.repeat_ticks);
            default:                    prdata = '0;
        endcase
    end

    mked_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (ctl)
    );

    mked_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_ctl        (ctl),
        .o_status     (status),
        .i_cmd        (i_cmd),
        .i_key_levels (i_key_levels),
        .i_key_index  (i_key_index),
        .i_flag_mask  (i_flag_mask),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_hit        (o_hit)
    );

endmodule

### tb/sv/multi_key_event_detector_tb.sv
`timescale 1ns / 1ps

module multi_key_event_detector_tb;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 16;

    localparam int NK = mked_pkg::NUM_KEYS;
    localparam int LW = mked_pkg::LEVEL_W;
    localparam int IW = mked_pkg::INDEX_W;
    localparam int FW = mked_pkg::FLAG_W;
    localparam int TW = mked_pkg::TIMER_W;
    localparam int SW = mked_pkg::SCAN_W;
    localparam int AW = mked_pkg::APB_ADDR_W;
    localparam int DW = mked_pkg::APB_DATA_W;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_MOSTLY,
        RX_PULSE
    } t_rx_mode;

    logic          i_clk        = 1'b0;
    logic          i_rst_n      = 1'b0;
    logic          psel         = 1'b0;
    logic          penable      = 1'b0;
    logic          pwrite       = 1'b0;
    logic [AW-1:0] paddr        = '0;
    logic [DW-1:0] pwdata       = '0;
    logic [DW-1:0] prdata;
    logic          pready;
    logic          i_in_valid   = 1'b0;
    logic          o_in_ready;
    logic          i_cmd        = mked_pkg::CMD_TICK;
    logic [LW-1:0] i_key_levels = '0;
    logic [IW-1:0] i_key_index  = '0;
    logic [FW-1:0] i_flag_mask  = '0;
    logic          o_out_valid;
    logic          i_out_ready  = 1'b0;
    logic          o_hit;

    multi_key_event_detector uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_key_levels (i_key_levels),
        .i_key_index  (i_key_index),
        .i_flag_mask  (i_flag_mask),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_hit        (o_hit)
    );

    always #4 i_clk = ~i_clk;

    // gesture model state
    mked_pkg::t_cfg   cfg_model;
    logic [SW-1:0]    scan_ctr;
    logic             lvl_cur  [NK];
    logic             lvl_prev [NK];
    mked_pkg::t_phase phase_q  [NK];
    logic [TW-1:0]    timer_q  [NK];
    logic [FW-1:0]    flags_q  [NK];

    logic     expected_hits [$];
    logic     hit_want;
    int       fail_count = 0;
    int       cycle_count = 0;
    int       burst_left = 0;
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_ctr = 0;

    function automatic void model_reset();
        cfg_model.scan_divider     = mked_pkg::SCAN_DIVIDER_RST;
        cfg_model.long_press_ticks = mked_pkg::LONG_PRESS_RST;
        cfg_model.double_gap_ticks = mked_pkg::DOUBLE_GAP_RST;
        cfg_model.repeat_ticks     = mked_pkg::REPEAT_RST;
        scan_ctr = '0;
        for (int k = 0; k < NK; k++) begin
            lvl_cur[k]  = 1'b0;
            lvl_prev[k] = 1'b0;
            phase_q[k]  = mked_pkg::PH_IDLE;
            timer_q[k]  = '0;
            flags_q[k]  = '0;
        end
    endfunction

    // one key sample: edge flags, then the gesture phase step
    function automatic void sample_key(input int k, input logic lvl);
        logic [FW-1:0] f;
        logic [TW-1:0] t;
        f = flags_q[k];
        t = timer_q[k];
        lvl_prev[k] = lvl_cur[k];
        lvl_cur[k]  = lvl;
        if (lvl) begin
            f = f | mked_pkg::FLAG_HELD;
        end else begin
            f = f & ~mked_pkg::FLAG_HELD;
        end
        if (lvl && !lvl_prev[k]) f = f | mked_pkg::FLAG_DOWN;
        if (!lvl && lvl_prev[k]) f = f | mked_pkg::FLAG_UP;
        case (phase_q[k])
            mked_pkg::PH_IDLE: begin
                if (lvl) begin
                    timer_q[k] = cfg_model.long_press_ticks;
                    phase_q[k] = mked_pkg::PH_HELD;
                end
            end
            mked_pkg::PH_HELD: begin
                if (!lvl) begin
                    timer_q[k] = cfg_model.double_gap_ticks;
                    phase_q[k] = mked_pkg::PH_GAP;
                end else if (t == '0) begin
                    timer_q[k] = cfg_model.repeat_ticks;
                    f = f | mked_pkg::FLAG_LONG;
                    phase_q[k] = mked_pkg::PH_REPEAT;
                end
            end
            mked_pkg::PH_GAP: begin
                if (lvl) begin
                    f = f | mked_pkg::FLAG_DOUBLE;
                    phase_q[k] = mked_pkg::PH_SECOND;
                end else if (t == '0) begin
                    f = f | mked_pkg::FLAG_SINGLE;
                    phase_q[k] = mked_pkg::PH_IDLE;
                end
            end
            mked_pkg::PH_SECOND: begin
                if (!lvl) phase_q[k] = mked_pkg::PH_IDLE;
            end
            mked_pkg::PH_REPEAT: begin
                if (!lvl) begin
                    phase_q[k] = mked_pkg::PH_IDLE;
                end else if (t == '0) begin
                    timer_q[k] = cfg_model.repeat_ticks;
                    f = f | mked_pkg::FLAG_REPEAT;
                end
            end
            default: begin
                phase_q[k] = mked_pkg::PH_IDLE;
            end
        endcase
        flags_q[k] = f;
    endfunction

    // expected hit of one word, advancing the model
    function automatic logic predict_hit(input logic cmd, input logic [LW-1:0] levels,
            input logic [IW-1:0] idx, input logic [FW-1:0] mask);
        logic hit;
        hit = 1'b0;
        if (cmd == mked_pkg::CMD_CHECK) begin
            if ((flags_q[idx] & mask) != '0) begin
                flags_q[idx] = flags_q[idx] & ~(mask & ~mked_pkg::FLAG_HELD);
                hit = 1'b1;
            end
        end else begin
            for (int k = 0; k < NK; k++) begin
                if (timer_q[k] != '0) timer_q[k] = timer_q[k] - 1'b1;
            end
            scan_ctr = scan_ctr + 1'b1;
            if (scan_ctr >= cfg_model.scan_divider) begin
                scan_ctr = '0;
                for (int k = 0; k < NK; k++) sample_key(k, levels[k]);
            end
        end
        return hit;
    endfunction

    // apb write: setup, access, then back to idle
    task automatic write_reg(input logic [1:0] reg_idx, input logic [DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_idx)
            mked_pkg::REG_SCAN_DIVIDER: cfg_model.scan_divider     = value[SW-1:0];
            mked_pkg::REG_LONG_PRESS:   cfg_model.long_press_ticks = value[TW-1:0];
            mked_pkg::REG_DOUBLE_GAP:   cfg_model.double_gap_ticks = value[TW-1:0];
            default:                    cfg_model.repeat_ticks     = value[TW-1:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_timing(input int divider, input int long_ticks, input int gap_ticks,
            input int rep_ticks);
        write_reg(mked_pkg::REG_SCAN_DIVIDER, DW'(divider));
        write_reg(mked_pkg::REG_LONG_PRESS, DW'(long_ticks));
        write_reg(mked_pkg::REG_DOUBLE_GAP, DW'(gap_ticks));
        write_reg(mked_pkg::REG_REPEAT, DW'(rep_ticks));
    endtask

    // send one word, bursts separated by random gaps
    task automatic send_word(input logic cmd, input logic [LW-1:0] levels,
            input logic [IW-1:0] idx, input logic [FW-1:0] mask);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_key_levels <= levels;
        i_key_index  <= idx;
        i_flag_mask  <= mask;
        do @(posedge i_clk); while (!o_in_ready);
        expected_hits.push_back(predict_hit(cmd, levels, idx, mask));
        burst_left--;
    endtask

    task automatic tick(input logic [LW-1:0] levels);
        send_word(mked_pkg::CMD_TICK, levels, IW'($urandom), FW'($urandom));
    endtask

    task automatic check(input logic [IW-1:0] idx, input logic [FW-1:0] mask);
        send_word(mked_pkg::CMD_CHECK, LW'($urandom), idx, mask);
    endtask

    // let every outstanding word come back before touching registers
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (expected_hits.size() != 0);
    endtask

    // key presses held for random runs, short ones for clicks, long ones for holds
    task automatic run_gestures(input int n_words, input int short_max, input int long_max,
            input int check_pct);
        int            hold_left [NK];
        logic [LW-1:0] levels;
        logic [FW-1:0] mask;
        levels = '0;
        for (int k = 0; k < NK; k++) hold_left[k] = $urandom_range(1, long_max);
        for (int n = 0; n < n_words; n++) begin
            if ($urandom_range(99) < check_pct) begin
                if ($urandom_range(1) == 1) begin
                    mask = FW'(1 << $urandom_range(6));
                end else begin
                    mask = FW'($urandom);
                end
                check(IW'($urandom), mask);
            end else if ($urandom_range(99) < 8) begin
                tick(LW'($urandom));
            end else begin
                for (int k = 0; k < NK; k++) begin
                    if (hold_left[k] == 0) begin
                        levels[k] = ~levels[k];
                        hold_left[k] = ($urandom_range(1) == 1)
                                       ? $urandom_range(1, short_max)
                                       : $urandom_range(1, long_max);
                    end else begin
                        hold_left[k]--;
                    end
                end
                tick(levels);
            end
        end
    endtask

    task automatic run_phase(input int divider, input int long_ticks, input int gap_ticks,
            input int rep_ticks, input int n_words, input int short_max, input int long_max,
            input int check_pct);
        wait_drained();
        set_timing(divider, long_ticks, gap_ticks, rep_ticks);
        run_gestures(n_words, short_max, long_max, check_pct);
    endtask

    // checks with an empty mask and with every flag
    task automatic test_fresh_checks();
        check(IW'(0), '0);
        check(IW'(3), 7'h7f);
    endtask

    // press and release once, then let the gap run out
    task automatic test_single_click();
        tick(4'h1);
        tick(4'h0);
        tick(4'h0);
        tick(4'h0);
        check(IW'(0), mked_pkg::FLAG_SINGLE);
        check(IW'(0), mked_pkg::FLAG_SINGLE);
    endtask

    // second press inside the gap gives double, not single
    task automatic test_double_click();
        tick(4'h8);
        tick(4'h0);
        tick(4'h8);
        tick(4'h0);
        check(IW'(3), mked_pkg::FLAG_DOUBLE);
        check(IW'(3), mked_pkg::FLAG_UP | mked_pkg::FLAG_DOWN | mked_pkg::FLAG_SINGLE);
    endtask

    // all keys held into long press and repeat; held bit survives checks
    task automatic test_long_repeat();
        repeat (5) tick(4'hf);
        check(IW'(1), mked_pkg::FLAG_LONG);
        check(IW'(2), mked_pkg::FLAG_REPEAT);
        check(IW'(0), mked_pkg::FLAG_HELD);
        check(IW'(0), mked_pkg::FLAG_HELD);
        check(IW'(3), 7'h7f);
        check(IW'(2), '0);
        tick(4'h0);
    endtask

    // receiver stalls and result checking
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_hits.size() == 0) begin
                $error("hit: result word with nothing expected, actual %0b", o_hit);
                fail_count++;
            end else begin
                hit_want = expected_hits.pop_front();
                if (o_hit !== hit_want) begin
                    $error("hit mismatch: expected %0b, actual %0b", hit_want, o_hit);
                    fail_count++;
                end
            end
        end
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(3));
            rx_left = $urandom_range(20, 200);
        end else begin
            rx_left--;
        end
        rx_ctr++;
        case (rx_mode)
            RX_OPEN:   i_out_ready <= 1'b1;
            RX_COIN:   i_out_ready <= ($urandom_range(1) == 1);
            RX_MOSTLY: i_out_ready <= ($urandom_range(3) != 0);
            default:   i_out_ready <= (rx_ctr % 12 == 0);
        endcase
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        model_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset timing values, only edges reachable in a short run
        run_gestures(60, 40, 400, 25);

        // directed gestures with tight timing
        wait_drained();
        set_timing(1, 2, 2, 1);
        test_fresh_checks();
        test_single_click();
        test_double_click();
        test_long_repeat();

        // random gestures across timing settings, extremes included
        run_phase(1, 4, 3, 2, 250, 3, 14, 25);
        run_phase(2, 6, 5, 3, 200, 8, 30, 25);
        run_phase(0, 0, 0, 0, 150, 2, 6, 30);
        run_phase(3, 1, 1, 1, 150, 4, 16, 25);
        run_phase(1, 10, 8, 5, 150, 6, 40, 20);
        run_phase(255, 65535, 65535, 65535, 300, 300, 600, 10);
        run_phase(5, 2, 3, 2, 150, 10, 40, 25);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
